// File: rtl/crank_tooth_speed_meter_macros.svh
// Assertion macros shared by the crank tooth speed meter checkers.
// Both macros expect clk, and CTSM_ASSERT_RUN rst_n too, in the scope of use.
`ifndef CRANK_TOOTH_SPEED_METER_MACROS_SVH
`define CRANK_TOOTH_SPEED_METER_MACROS_SVH

// Checked only while reset is released.
`define CTSM_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CTSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ctsm_pkg.sv
// Package for the crank tooth speed meter: widths, reset values, codes and types.
// Used by the interfaces, the divider, the top level and the checker.
package ctsm_pkg;

  localparam int CTSM_MAX_TEETH = 256;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [8:0]  GEAR_COUNT_RST     = 9'd60;
  localparam logic [31:0] SCALE_RST          = 32'd185000000;
  localparam logic [15:0] SPEED_MIN_RST      = 16'd100;
  localparam logic [15:0] SPEED_MAX_RST      = 16'd8000;
  localparam logic [4:0]  SILENCE_LIMIT_RST  = 5'd25;
  localparam logic [15:0] FALLBACK_SPEED_RST = 16'd30;
  localparam logic [15:0] AVG_SAT            = 16'hFFFF;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GEAR_COUNT     = 3'd0,
    REG_SCALE          = 3'd1,
    REG_SPEED_MIN      = 3'd2,
    REG_SPEED_MAX      = 3'd3,
    REG_SILENCE_LIMIT  = 3'd4,
    REG_FALLBACK_SPEED = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_READ,
    ST_UPDATE,
    ST_SPD_GO,
    ST_SPD_WAIT,
    ST_GEAR_GO,
    ST_GEAR_WAIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/ctsm_if.sv
// Valid/ready channel interfaces for the crank tooth speed meter.
// Depends on ctsm_pkg for the configuration port widths.
interface ctsm_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] capture_time;

  modport source (output valid, output opcode, output capture_time, input ready);
  modport sink (input valid, input opcode, input capture_time, output ready);
endinterface

interface ctsm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_rpm;

  modport source (output valid, output speed_rpm, input ready);
  modport sink (input valid, input speed_rpm, output ready);
endinterface

interface ctsm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ctsm_pkg::CFG_IDX_W-1:0]   index;
  logic [ctsm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/ctsm_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on ctsm_pkg for the status struct.
module ctsm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [15:0]         divisor,
  output ctsm_pkg::div_stat_t stat,
  output logic [31:0]         quotient
);
  import ctsm_pkg::*;

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[31]};
    rem_sub = rem_sh - {1'b0, divisor};
    ge      = (rem_sh >= {1'b0, divisor});
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
      q_nxt    = dividend;
      rem_nxt  = 16'd0;
    end else if (busy_r) begin
      q_nxt   = {q_r[30:0], ge};
      rem_nxt = ge ? rem_sub[15:0] : rem_sh[15:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

// File: rtl/crank_tooth_speed_meter.sv
// Crank tooth speed meter: tooth period window, average and speed from capture words.
// A tick word gives its result in the output register in the cycle after it is accepted.
// A capture word stalls the input through its read and update states and through each
// pass of the shared 32-step divider: one pass on a slot wrap, two when the average is
// nonzero. After reset every entry of the interval store is zeroed before any input
// word is taken; configuration writes are taken in every state.
module crank_tooth_speed_meter #(
  parameter int MAX_TEETH = ctsm_pkg::CTSM_MAX_TEETH
) (
  input  logic        clk,
  input  logic        rst_n,
  ctsm_in_if.sink     in_ch,
  ctsm_out_if.source  out_ch,
  ctsm_cfg_if.sink    cfg_ch
);
  import ctsm_pkg::*;

  localparam int IDX_W = $clog2(MAX_TEETH);
  localparam int GW    = $clog2(MAX_TEETH + 1);
  localparam int EW    = (GW > 9) ? GW : 9;
  localparam int CW    = IDX_W + 1;

  state_t state_r, state_nxt;

  logic [8:0]  gear_count_r;
  logic [31:0] scale_r;
  logic [15:0] speed_min_r;
  logic [15:0] speed_max_r;
  logic [4:0]  silence_limit_r;
  logic [15:0] fallback_r;

  logic [IDX_W-1:0] clr_r;
  logic [IDX_W-1:0] slot_r;
  logic [15:0]      prev_r;
  logic [15:0]      cap_r;
  logic [23:0]      sum_r;
  logic [15:0]      avg_r;
  logic [31:0]      speed_r;
  logic [4:0]       sil_r;
  logic             out_valid_r;
  logic [15:0]      out_speed_r;

  logic [15:0]      mem [MAX_TEETH];
  logic [15:0]      rd_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [15:0]      mem_wd;

  logic [EW-1:0]    gc_ext;
  logic [GW-1:0]    gears;
  logic [CW-1:0]    slot_plus;
  logic             wrap;
  logic             in_acc;
  logic             cap_acc;
  logic             tick_acc;
  logic             out_free;
  logic             clr_last;
  logic [15:0]      gap;

  logic                div_start;
  logic [31:0]         div_dividend;
  logic [15:0]         div_divisor;
  div_stat_t           div_stat;
  logic [31:0]         div_q;

  ctsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    gc_ext = EW'(gear_count_r);
    if (gc_ext == '0) begin
      gears = GW'(1);
    end else if (gc_ext > EW'(MAX_TEETH)) begin
      gears = GW'(MAX_TEETH);
    end else begin
      gears = GW'(gc_ext);
    end
  end

  assign slot_plus = {1'b0, slot_r} + CW'(1);
  assign wrap      = (slot_plus >= CW'(gears));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cap_acc   = in_acc && (in_ch.opcode == OP_CAPTURE);
  assign tick_acc  = in_acc && (in_ch.opcode == OP_TICK);
  assign clr_last  = (clr_r == IDX_W'(MAX_TEETH - 1));
  assign gap       = cap_r - prev_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cap_acc) state_nxt = wrap ? ST_AVG_GO : ST_READ;
      end
      ST_AVG_GO:   state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (div_stat.done) state_nxt = ST_READ;
      end
      ST_READ:     state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = (avg_r != 16'd0) ? ST_SPD_GO : ST_IDLE;
      ST_SPD_GO:   state_nxt = ST_SPD_WAIT;
      ST_SPD_WAIT: begin
        if (div_stat.done) state_nxt = ST_GEAR_GO;
      end
      ST_GEAR_GO:  state_nxt = ST_GEAR_WAIT;
      ST_GEAR_WAIT: begin
        if (div_stat.done) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_q;
    div_divisor  = 16'(gears);
    mem_we       = 1'b0;
    mem_wa       = slot_r;
    mem_wd       = gap;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = 16'd0;
      end
      ST_IDLE: begin
        in_ch.ready = out_free;
      end
      ST_AVG_GO: begin
        div_start    = 1'b1;
        div_dividend = {8'd0, sum_r};
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
      end
      ST_SPD_GO: begin
        div_start    = 1'b1;
        div_dividend = scale_r;
        div_divisor  = avg_r;
      end
      ST_SPD_WAIT: begin
        div_divisor = avg_r;
      end
      ST_GEAR_GO: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.speed_rpm = out_speed_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_count_r    <= GEAR_COUNT_RST;
      scale_r         <= SCALE_RST;
      speed_min_r     <= SPEED_MIN_RST;
      speed_max_r     <= SPEED_MAX_RST;
      silence_limit_r <= SILENCE_LIMIT_RST;
      fallback_r      <= FALLBACK_SPEED_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        REG_GEAR_COUNT:     gear_count_r    <= cfg_ch.data[8:0];
        REG_SCALE:          scale_r         <= cfg_ch.data;
        REG_SPEED_MIN:      speed_min_r     <= cfg_ch.data[15:0];
        REG_SPEED_MAX:      speed_max_r     <= cfg_ch.data[15:0];
        REG_SILENCE_LIMIT:  silence_limit_r <= cfg_ch.data[4:0];
        REG_FALLBACK_SPEED: fallback_r      <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      slot_r      <= '0;
      prev_r      <= 16'd0;
      sum_r       <= 24'd0;
      avg_r       <= 16'd0;
      speed_r     <= 32'd0;
      sil_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cap_acc) begin
        sil_r  <= 5'd0;
        slot_r <= wrap ? '0 : slot_plus[IDX_W-1:0];
      end
      if (tick_acc) begin
        out_valid_r <= 1'b1;
        if (sil_r >= silence_limit_r) begin
          out_speed_r <= 16'd0;
        end else begin
          sil_r <= sil_r + 5'd1;
          if ((speed_r > {16'd0, speed_max_r}) || (speed_r < {16'd0, speed_min_r})) begin
            out_speed_r <= fallback_r;
          end else begin
            out_speed_r <= speed_r[15:0];
          end
        end
      end
      if ((state_r == ST_AVG_WAIT) && div_stat.done) begin
        avg_r <= (div_q[31:16] != 16'd0) ? AVG_SAT : div_q[15:0];
      end
      if (state_r == ST_UPDATE) begin
        sum_r  <= sum_r - {8'd0, rd_r} + {8'd0, gap};
        prev_r <= cap_r;
      end
      if ((state_r == ST_GEAR_WAIT) && div_stat.done) begin
        speed_r <= div_q;
      end
    end
    if (cap_acc) begin
      cap_r <= in_ch.capture_time;
    end
  end

endmodule

// File: rtl/ctsm_checker.sv
// Port-level checker for the crank tooth speed meter, attached by bind.
// Depends on ctsm_pkg and on the assertion macros header.
`include "crank_tooth_speed_meter_macros.svh"

module ctsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_speed
);
  import ctsm_pkg::*;

  `CTSM_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> !in_ready, "input taken during clearing pass")
  `CTSM_ASSERT_RUN(a_capture_busy, (in_valid && in_ready && in_opcode == OP_CAPTURE) |=> !in_ready, "ready right after a capture")
  `CTSM_ASSERT_RUN(a_result_from_tick, $rose(out_valid) |-> $past(in_valid && in_ready && in_opcode == OP_TICK), "result without a tick")
  `CTSM_ASSERT_RUN(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_speed)), "stalled result changed")

endmodule

bind crank_tooth_speed_meter ctsm_checker u_ctsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_speed (out_ch.speed_rpm)
);
